>>> hdl/dtv_pkg.sv
// ----------------------------------------------------------------------------
// dtv_pkg
// Shared types and constants of the timestamp text validator.
// ----------------------------------------------------------------------------
package dtv_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int RES_DEPTH   = 2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [13:0] MAX_DAY      = 14'd31;
    localparam logic [13:0] MAX_MONTH    = 14'd12;
    localparam logic [13:0] MAX_HOUR     = 14'd23;
    localparam logic [13:0] MAX_MIN_SEC  = 14'd59;
    localparam logic [4:0]  DAY_SHORT    = 5'd30;
    localparam logic [4:0]  DAY_FEB_LEAP = 5'd29;
    localparam logic [4:0]  DAY_FEB      = 5'd28;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;

    typedef enum logic [1:0] {
        K_DIGIT,
        K_COLON,
        K_SPACE,
        K_OTHER
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
        logic       last;
    } t_cmd;

    typedef enum logic [2:0] {
        F_DAY,
        F_MONTH,
        F_YEAR,
        F_HOUR,
        F_MINUTE,
        F_SECOND,
        F_DONE
    } t_field;

    typedef struct packed {
        logic        valid;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_result;

    typedef struct packed {
        t_field      step;
        logic [2:0]  cnt;
        logic [13:0] acc;
        logic [3:0]  prev;
        logic [6:0]  lo2;
        logic [6:0]  hi2;
        logic        failed;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_parse;

    localparam t_parse PARSE_IDLE = '0;

endpackage

>>> hdl/datetime_text_validator.sv
// ----------------------------------------------------------------------------
// datetime_text_validator
// Checks "dd:MM:yyyy hh:mm:ss" timestamp text (a colon may also follow the year)
// arriving one character a word.
// Input channel: push with char_code and is_last; a word is taken when push
// is high and full is low. Output channel: one result word per string, shown
// while empty is low and taken when pop is high; it carries valid_res and the
// six parsed fields, all zero for an invalid string.
// Throughput: one character per cycle while the result buffer has room. Each
// character is handled by the parser as it leaves a four-word command queue.
// The last character of a string is registered in the command queue, and its
// result is then registered in the result buffer before empty falls.
// Reset: clears both queues and the parser; the next word starts a string.
// Stall: a two-word result buffer holds finished results; when it is full
// the parser stops draining the command queue, and full rises once that
// queue holds four words.
// ----------------------------------------------------------------------------
module datetime_text_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_code,
    input  logic        i_is_last,
    output logic        empty,
    input  logic        pop,
    output logic        o_valid_res,
    output logic [4:0]  o_day,
    output logic [3:0]  o_month,
    output logic [13:0] o_year,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    dtv_pkg::t_cmd    cmd_in;
    dtv_pkg::t_cmd    cmd_q;
    logic             q_empty;
    logic             q_pop;
    dtv_pkg::t_result res;

    dtv_front u_front (
        .i_char_code (i_char_code),
        .i_is_last   (i_is_last),
        .o_cmd       (cmd_in)
    );

    dtv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_cmd   (cmd_q),
        .o_empty (q_empty)
    );

    dtv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_q),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_valid_res = res.valid;
    assign o_day       = res.day;
    assign o_month     = res.month;
    assign o_year      = res.year;
    assign o_hour      = res.hour;
    assign o_minute    = res.minute;
    assign o_second    = res.second;

endmodule

>>> hdl/dtv_front.sv
// ----------------------------------------------------------------------------
// dtv_front
// Classifies one incoming character into a parser command.
// ----------------------------------------------------------------------------
module dtv_front (
    input  logic [7:0]    i_char_code,
    input  logic          i_is_last,
    output dtv_pkg::t_cmd o_cmd
);

    always_comb begin
        o_cmd.last  = i_is_last;
        o_cmd.digit = i_char_code[3:0];
        if (i_char_code >= dtv_pkg::CHAR_ZERO && i_char_code <= dtv_pkg::CHAR_NINE) begin
            o_cmd.kind = dtv_pkg::K_DIGIT;
        end else if (i_char_code == dtv_pkg::CHAR_COLON) begin
            o_cmd.kind = dtv_pkg::K_COLON;
        end else if (i_char_code == dtv_pkg::CHAR_SPACE) begin
            o_cmd.kind = dtv_pkg::K_SPACE;
        end else begin
            o_cmd.kind = dtv_pkg::K_OTHER;
        end
    end

endmodule

>>> hdl/dtv_queue.sv
// ----------------------------------------------------------------------------
// dtv_queue
// Short command queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module dtv_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dtv_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output dtv_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    dtv_pkg::t_cmd                r_mem [dtv_pkg::QUEUE_DEPTH];
    logic [dtv_pkg::QUEUE_AW-1:0] r_wp;
    logic [dtv_pkg::QUEUE_AW-1:0] r_rp;
    logic [dtv_pkg::QUEUE_AW:0]   r_cnt;
    logic                         wr_en;
    logic                         rd_en;

    assign o_full  = (r_cnt == (dtv_pkg::QUEUE_AW+1)'(dtv_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> hdl/dtv_back.sv
// ----------------------------------------------------------------------------
// dtv_back
// Field parser with range checks and a two-entry result buffer.
// ----------------------------------------------------------------------------
module dtv_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dtv_pkg::t_cmd    i_cmd,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output dtv_pkg::t_result o_res
);

    function automatic dtv_pkg::t_parse close_field(dtv_pkg::t_parse s);
        dtv_pkg::t_parse r;
        logic [2:0]      need;
        logic            leap;
        r    = s;
        need = (s.step == dtv_pkg::F_YEAR) ? 3'd4 : 3'd2;
        leap = (s.lo2 != '0) ? (s.lo2[1:0] == 2'b00) : (s.hi2[1:0] == 2'b00);
        if (s.cnt != need) begin
            r.failed = 1'b1;
        end else begin
            unique case (s.step)
                dtv_pkg::F_DAY: begin
                    if (s.acc == '0 || s.acc > dtv_pkg::MAX_DAY) r.failed = 1'b1;
                    else r.day = s.acc[4:0];
                end
                dtv_pkg::F_MONTH: begin
                    if (s.acc == '0 || s.acc > dtv_pkg::MAX_MONTH) begin
                        r.failed = 1'b1;
                    end else if ((s.acc == 14'd4 || s.acc == 14'd6 || s.acc == 14'd9 ||
                                  s.acc == 14'd11) && s.day > dtv_pkg::DAY_SHORT) begin
                        r.failed = 1'b1;
                    end else if (s.acc[3:0] == dtv_pkg::MONTH_FEB &&
                                 s.day > dtv_pkg::DAY_FEB_LEAP) begin
                        r.failed = 1'b1;
                    end else begin
                        r.month = s.acc[3:0];
                    end
                end
                dtv_pkg::F_YEAR: begin
                    if (!leap && s.month == dtv_pkg::MONTH_FEB && s.day > dtv_pkg::DAY_FEB)
                        r.failed = 1'b1;
                    else r.year = s.acc;
                end
                dtv_pkg::F_HOUR: begin
                    if (s.acc > dtv_pkg::MAX_HOUR) r.failed = 1'b1;
                    else r.hour = s.acc[4:0];
                end
                dtv_pkg::F_MINUTE: begin
                    if (s.acc > dtv_pkg::MAX_MIN_SEC) r.failed = 1'b1;
                    else r.minute = s.acc[5:0];
                end
                default: begin
                    if (s.acc > dtv_pkg::MAX_MIN_SEC) r.failed = 1'b1;
                    else r.second = s.acc[5:0];
                end
            endcase
        end
        if (!r.failed) begin
            r.step = dtv_pkg::t_field'(s.step + 3'd1);
            r.cnt  = '0;
            r.acc  = '0;
            r.prev = '0;
            r.lo2  = '0;
            r.hi2  = '0;
        end
        return r;
    endfunction

    function automatic dtv_pkg::t_parse take_char(dtv_pkg::t_parse s, dtv_pkg::t_cmd c);
        dtv_pkg::t_parse r;
        logic [2:0]      need;
        r    = s;
        need = (s.step == dtv_pkg::F_YEAR) ? 3'd4 : 3'd2;
        if (c.kind == dtv_pkg::K_DIGIT) begin
            if (s.cnt >= need) begin
                r.failed = 1'b1;
            end else begin
                r.cnt  = s.cnt + 3'd1;
                r.acc  = {s.acc[10:0], 3'b000} + {s.acc[12:0], 1'b0} + {10'd0, c.digit};
                r.lo2  = {s.prev, 3'b000} + {2'b00, s.prev, 1'b0} + {3'b000, c.digit};
                r.hi2  = (s.cnt == 3'd2) ? s.lo2 : s.hi2;
                r.prev = c.digit;
            end
        end else if (c.kind == dtv_pkg::K_COLON ||
                     (c.kind == dtv_pkg::K_SPACE && s.step == dtv_pkg::F_YEAR)) begin
            if (s.step >= dtv_pkg::F_SECOND) r.failed = 1'b1;
            else r = close_field(s);
        end else begin
            r.failed = 1'b1;
        end
        return r;
    endfunction

    dtv_pkg::t_parse  r_ps;
    dtv_pkg::t_parse  n_ps;
    dtv_pkg::t_parse  s_take;
    dtv_pkg::t_parse  s_end;
    dtv_pkg::t_result res_new;
    dtv_pkg::t_result r_res [dtv_pkg::RES_DEPTH];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             res_wr;
    logic             res_rd;
    logic             ok;

    always_comb begin
        o_q_pop = !i_q_empty && (r_cnt != 2'(dtv_pkg::RES_DEPTH));
        res_wr  = o_q_pop && i_cmd.last;
        res_rd  = i_pop && !o_empty;
    end

    always_comb begin
        s_take = r_ps.failed ? r_ps : take_char(r_ps, i_cmd);
        s_end  = s_take;
        if (!s_take.failed) begin
            if (s_take.step == dtv_pkg::F_SECOND) s_end = close_field(s_take);
            else s_end.failed = 1'b1;
        end
        ok = !s_end.failed && (s_end.step == dtv_pkg::F_DONE);
        res_new = '0;
        if (ok) begin
            res_new.valid  = 1'b1;
            res_new.day    = s_end.day;
            res_new.month  = s_end.month;
            res_new.year   = s_end.year;
            res_new.hour   = s_end.hour;
            res_new.minute = s_end.minute;
            res_new.second = s_end.second;
        end
        if (!o_q_pop) n_ps = r_ps;
        else if (i_cmd.last) n_ps = dtv_pkg::PARSE_IDLE;
        else n_ps = s_take;
    end

    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_res[r_rp];

    always_ff @(posedge i_clk) begin
        if (res_wr) begin
            r_res[r_wp] <= res_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps  <= dtv_pkg::PARSE_IDLE;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_ps <= n_ps;
            if (res_wr) r_wp <= ~r_wp;
            if (res_rd) r_rp <= ~r_rp;
            if (res_wr && !res_rd) r_cnt <= r_cnt + 2'd1;
            else if (res_rd && !res_wr) r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

>>> hdl/dtv_checker.sv
// ----------------------------------------------------------------------------
// dtv_checker
// Port-level checks of the timestamp text validator, bound to the top level.
// ----------------------------------------------------------------------------
module dtv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        o_valid_res,
    input logic [4:0]  o_day,
    input logic [3:0]  o_month,
    input logic [13:0] o_year,
    input logic [4:0]  o_hour,
    input logic [5:0]  o_minute,
    input logic [5:0]  o_second
);

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_valid_res) && $stable(o_day) &&
        $stable(o_month) && $stable(o_year) && $stable(o_hour) &&
        $stable(o_minute) && $stable(o_second))
        else $error("stalled result changed");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_valid_res |-> o_day == 5'd0 && o_month == 4'd0 &&
        o_year == 14'd0 && o_hour == 5'd0 && o_minute == 6'd0 && o_second == 6'd0)
        else $error("invalid result with nonzero fields");

    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_valid_res |-> o_day != 5'd0 && o_day <= 5'd31 &&
        o_month != 4'd0 && o_month <= 4'd12 && o_hour <= 5'd23 &&
        o_minute <= 6'd59 && o_second <= 6'd59)
        else $error("valid result out of range");

endmodule

bind datetime_text_validator dtv_checker u_dtv_checker (.*);
